>>> sv/rwca_pkg.sv
// shared types and constants for the reorder window with cumulative ack
`timescale 1ns / 1ps
package rwca_pkg;

  localparam int unsigned WINDOW = 32;
  localparam int unsigned SLOT_W = $clog2(WINDOW);

  localparam logic [8:0] FULL_LEN = 9'd500;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  // input operations
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    K_DELIVER = 2'd0,
    K_ACK     = 2'd1,
    K_OPEN    = 2'd2,
    K_CLOSE   = 2'd3
  } kind_t;

  // shared adder operations
  typedef enum logic [1:0] {
    ALU_INC = 2'd0,
    ALU_SUB = 2'd1,
    ALU_DEC = 2'd2
  } alu_op_t;

  // control from the sequencer to the slot store
  typedef struct packed {
    logic      wr_en;
    slot_idx_t wr_idx;
    logic      rd_en;
    slot_idx_t rd_idx;
    logic      clr_en;
    slot_idx_t clr_idx;
  } slot_ctl_t;

endpackage

>>> sv/reorder_window_cumulative_ack.sv
// top level: receive reorder window sequencer with cumulative ack
`timescale 1ns / 1ps
// usage
//   input channel: drive in_* with start high; the beat is taken at a rising edge
//   where start is high and busy is low. busy stays high until the last result of
//   that beat is registered; it shows in the first idle cycle, or earlier after close.
//   result channel: each result sits on out_* for one cycle with out_strobe high;
//   out_run_end marks the last result of an input beat. the receiver cannot stall.
//   sequencing (one beat at a time, shared 32-bit adder), busy steps
//   per beat, each result strobed in the cycle after the step that makes it:
//     open / close: the first step, which makes the reply
//     unparsable:   the first step, then the ack step
//     data:         expected sequence, offset and store steps place the packet;
//                   an in-order packet then takes a slot check, count decrement
//                   and sequence increment per delivered packet (the last two
//                   through the one adder) and a slot check that ends the run;
//                   an ack step closes every data beat
//   the payload memory is read one slot per delivery through its registered port.
//   reset: synchronous, active low; clears sequence, head, count, tail length,
//   closed flag and all present flags. payload memory is not cleared.
module reorder_window_cumulative_ack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_sequence_req,
  input  logic [63:0] in_payload_word,
  input  logic [31:0] in_packet_count,
  input  logic [8:0]  in_final_length,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [63:0] out_payload_out,
  output logic [8:0]  out_byte_length,
  output logic [31:0] out_number_out,
  output logic        out_run_end
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INC   = 8'b0000_0010,
    S_DIFF  = 8'b0000_0100,
    S_STORE = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_DEC   = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_ACK   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // latched input beat
  rwca_pkg::op_t op_r;
  logic [31:0]   seq_r;
  logic [63:0]   pay_r;
  logic [31:0]   cnt_r;
  logic [8:0]    flen_r;

  // connection state
  logic [31:0]         ioh_r, ioh_nxt;
  rwca_pkg::slot_idx_t head_r, head_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [8:0]          tail_r, tail_nxt;
  logic                closed_r, closed_nxt;

  // scratch for the placement steps
  logic [31:0]         exp_r, exp_nxt;    // in_order_high + 1
  logic                in_win_r, in_win_nxt;
  logic                dzero_r, dzero_nxt;
  rwca_pkg::slot_idx_t doff_r, doff_nxt;

  // result register
  logic        strobe_r, strobe_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [63:0] opay_r, opay_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [31:0] num_r, num_nxt;
  logic        end_r, end_nxt;

  // shared adder
  rwca_pkg::alu_op_t alu_op;
  logic [31:0]       alu_a, alu_b, alu_res;

  // slot store
  rwca_pkg::slot_ctl_t         slot_ctl;
  logic [rwca_pkg::WINDOW-1:0] present;
  logic [63:0]                 rd_data;
  rwca_pkg::slot_idx_t         head_inc;

  logic accept;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign head_inc = head_r + rwca_pkg::slot_idx_t'(1);

  rwca_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  rwca_slots u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (slot_ctl),
    .wr_data (pay_r),
    .present (present),
    .rd_data (rd_data)
  );

  // adder operand selection by step
  always_comb begin
    alu_op = rwca_pkg::ALU_INC;
    alu_a  = ioh_r;
    alu_b  = exp_r;
    case (state_r)
      S_DIFF: begin
        alu_op = rwca_pkg::ALU_SUB;
        alu_a  = seq_r;
      end
      S_DEC: begin
        alu_op = rwca_pkg::ALU_DEC;
        alu_a  = rem_r;
      end
      default: begin
        alu_op = rwca_pkg::ALU_INC;
        alu_a  = ioh_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ioh_nxt    = ioh_r;
    head_nxt   = head_r;
    rem_nxt    = rem_r;
    tail_nxt   = tail_r;
    closed_nxt = closed_r;
    exp_nxt    = exp_r;
    in_win_nxt = in_win_r;
    dzero_nxt  = dzero_r;
    doff_nxt   = doff_r;

    strobe_nxt = 1'b0;
    kind_nxt   = rwca_pkg::K_ACK;
    opay_nxt   = 64'd0;
    len_nxt    = 9'd0;
    num_nxt    = 32'd0;
    end_nxt    = 1'b0;

    slot_ctl         = '0;
    slot_ctl.wr_idx  = head_r + doff_r;
    slot_ctl.rd_idx  = head_r;
    slot_ctl.clr_idx = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        case (op_r)
          rwca_pkg::OP_OPEN: begin
            rem_nxt  = cnt_r;
            // zero and out-of-range lengths stand for a full packet
            tail_nxt = ((flen_r == 9'd0) || (flen_r > rwca_pkg::FULL_LEN)) ?
                       rwca_pkg::FULL_LEN : flen_r;
            strobe_nxt = 1'b1;
            kind_nxt   = rwca_pkg::K_OPEN;
            end_nxt    = 1'b1;
            state_nxt  = S_IDLE;
          end
          rwca_pkg::OP_CLOSE: begin
            closed_nxt = 1'b1;
            strobe_nxt = 1'b1;
            kind_nxt   = rwca_pkg::K_CLOSE;
            end_nxt    = 1'b1;
            state_nxt  = S_IDLE;
          end
          rwca_pkg::OP_DATA: begin
            exp_nxt   = alu_res;
            state_nxt = S_DIFF;
          end
          default: begin
            state_nxt = S_ACK;
          end
        endcase
      end
      S_DIFF: begin
        // offset of this sequence from the next expected one
        in_win_nxt = (alu_res[31:rwca_pkg::SLOT_W] == '0);
        dzero_nxt  = (alu_res == 32'd0);
        doff_nxt   = alu_res[rwca_pkg::SLOT_W-1:0];
        state_nxt  = S_STORE;
      end
      S_STORE: begin
        slot_ctl.wr_en = in_win_r;
        state_nxt      = dzero_r ? S_READ : S_ACK;
      end
      S_READ: begin
        // drain the contiguous run starting at the head
        if (present[head_r]) begin
          slot_ctl.rd_en = 1'b1;
          state_nxt      = S_DEC;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_DEC: begin
        rem_nxt   = (rem_r == 32'd0) ? 32'd0 : alu_res;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ioh_nxt         = alu_res;
        head_nxt        = head_inc;
        slot_ctl.clr_en = 1'b1;
        strobe_nxt      = 1'b1;
        kind_nxt        = rwca_pkg::K_DELIVER;
        opay_nxt        = rd_data;
        len_nxt         = (rem_r == 32'd0) ? tail_r : rwca_pkg::FULL_LEN;
        num_nxt         = alu_res;
        // with acks suppressed the last delivery ends the run
        end_nxt         = closed_r && !present[head_inc];
        state_nxt       = S_READ;
      end
      S_ACK: begin
        if (!closed_r) begin
          strobe_nxt = 1'b1;
          kind_nxt   = rwca_pkg::K_ACK;
          num_nxt    = ioh_r;
          end_nxt    = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ioh_r    <= 32'd0;
      head_r   <= '0;
      rem_r    <= 32'd0;
      tail_r   <= 9'd0;
      closed_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ioh_r    <= ioh_nxt;
      head_r   <= head_nxt;
      rem_r    <= rem_nxt;
      tail_r   <= tail_nxt;
      closed_r <= closed_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // latched input beat, scratch and result data registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= rwca_pkg::op_t'(in_operation);
      seq_r  <= in_sequence_req;
      pay_r  <= in_payload_word;
      cnt_r  <= in_packet_count;
      flen_r <= in_final_length;
    end
    exp_r    <= exp_nxt;
    in_win_r <= in_win_nxt;
    dzero_r  <= dzero_nxt;
    doff_r   <= doff_nxt;
    kind_r   <= kind_nxt;
    opay_r   <= opay_nxt;
    len_r    <= len_nxt;
    num_r    <= num_nxt;
    end_r    <= end_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_kind        = kind_r;
  assign out_payload_out = opay_r;
  assign out_byte_length = len_r;
  assign out_number_out  = num_r;
  assign out_run_end     = end_r;

endmodule

>>> sv/rwca_alu.sv
// shared 32-bit adder: increment, decrement and subtract
`timescale 1ns / 1ps
module rwca_alu (
  input  rwca_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       res
);

  logic [31:0] b_eff;
  logic        cin;

  always_comb begin
    case (op)
      rwca_pkg::ALU_INC: begin
        b_eff = 32'd0;
        cin   = 1'b1;
      end
      rwca_pkg::ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      rwca_pkg::ALU_DEC: begin
        b_eff = 32'hFFFF_FFFF;
        cin   = 1'b0;
      end
      default: begin
        b_eff = 32'd0;
        cin   = 1'b0;
      end
    endcase
  end

  assign res = a + b_eff + {31'd0, cin};

endmodule

>>> sv/rwca_slots.sv
// window slot store: payload memory and present flags
`timescale 1ns / 1ps
module rwca_slots (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rwca_pkg::slot_ctl_t           ctl,
  input  logic [63:0]                   wr_data,
  output logic [rwca_pkg::WINDOW-1:0]   present,
  output logic [63:0]                   rd_data
);

  logic [63:0]                 mem [rwca_pkg::WINDOW];
  logic [rwca_pkg::WINDOW-1:0] present_r;
  logic [63:0]                 rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      if (ctl.wr_en) begin
        present_r[ctl.wr_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        present_r[ctl.clr_idx] <= 1'b0;
      end
    end
  end

  assign present = present_r;
  assign rd_data = rd_data_r;

endmodule

>>> sim/rwca_scoreboard_pkg.sv
// scoreboard class: predicts reorder window results and checks them in order
`timescale 1ns / 1ps
package rwca_scoreboard_pkg;
  import rwca_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [63:0] payload;
    logic [8:0]  length;
    logic [31:0] number;
    logic        run_end;
  } rwca_result_t;

  class rwca_scoreboard;
    logic [31:0]  in_order_high;
    logic         present [WINDOW];
    logic [63:0]  payload_mem [WINDOW];
    slot_idx_t    head;
    logic [31:0]  remaining;
    logic [8:0]   tail_len;
    logic         closed;
    rwca_result_t pending [$];
    int unsigned  mismatches;

    function new();
      in_order_high = '0;
      foreach (present[i]) present[i] = 1'b0;
      head       = '0;
      remaining  = '0;
      tail_len   = '0;
      closed     = 1'b0;
      mismatches = 0;
    endfunction

    function rwca_result_t make_result(kind_t kind, logic [63:0] payload,
                                       logic [8:0] length, logic [31:0] number);
      rwca_result_t r;
      r.kind    = kind;
      r.payload = payload;
      r.length  = length;
      r.number  = number;
      r.run_end = 1'b0;
      return r;
    endfunction

    // advance the window model by one accepted beat and queue its results
    function void note_input(op_t op, logic [31:0] seq, logic [63:0] pay,
                             logic [31:0] cnt, logic [8:0] flen);
      rwca_result_t burst [$];
      logic [31:0]  dist_ahead;
      slot_idx_t    idx;
      case (op)
        OP_OPEN: begin
          remaining = cnt;
          tail_len  = (flen == 9'd0 || flen > FULL_LEN) ? FULL_LEN : flen;
          burst.insert(burst.size(), make_result(K_OPEN, '0, '0, '0));
        end
        OP_CLOSE: begin
          closed = 1'b1;
          burst.insert(burst.size(), make_result(K_CLOSE, '0, '0, '0));
        end
        default: begin
          if (op == OP_DATA) begin
            dist_ahead = seq - (in_order_high + 32'd1);
            if (dist_ahead < WINDOW) begin
              idx = head + slot_idx_t'(dist_ahead[SLOT_W-1:0]);
              present[idx]     = 1'b1;
              payload_mem[idx] = pay;
            end
            if (dist_ahead == 32'd0) begin
              while (present[head]) begin
                if (remaining != 32'd0) remaining = remaining - 32'd1;
                in_order_high = in_order_high + 32'd1;
                burst.insert(burst.size(),
                             make_result(K_DELIVER, payload_mem[head],
                                         (remaining == 32'd0) ? tail_len : FULL_LEN,
                                         in_order_high));
                present[head] = 1'b0;
                head = head + slot_idx_t'(1);
              end
            end
          end
          if (!closed)
            burst.insert(burst.size(), make_result(K_ACK, '0, '0, in_order_high));
        end
      endcase
      if (burst.size() > 0) burst[burst.size()-1].run_end = 1'b1;
      foreach (burst[i]) pending.insert(pending.size(), burst[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [63:0] payload,
                               logic [8:0] length, logic [31:0] number, logic run_end);
      rwca_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: kind %0d payload %h length %0d number %0d",
                   $time, kind, payload, length, number);
        return;
      end
      exp = pending.pop_front();
      if (kind !== exp.kind || payload !== exp.payload || length !== exp.length ||
          number !== exp.number || run_end !== exp.run_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t (expected/actual): kind %0d/%0d payload %h/%h",
                   $time, exp.kind, kind, exp.payload, payload);
          $display("  length %0d/%0d number %0d/%0d run_end %0b/%0b",
                   exp.length, length, exp.number, number, exp.run_end, run_end);
        end
      end
    endfunction
  endclass

endpackage

>>> sim/reorder_window_cumulative_ack_tb.sv
// testbench top: drives open, data, close and unparsable beats and checks every result
`timescale 1ns / 1ps
module reorder_window_cumulative_ack_tb;
  import rwca_pkg::*;
  import rwca_scoreboard_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned RANDOM_BEATS = 280;
  localparam int unsigned CLOSED_BEATS = 20;
  // the limit lies well above a full window drain plus the longest sender gap
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 100;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [1:0]  in_operation    = 2'd0;
  logic [31:0] in_sequence_req = '0;
  logic [63:0] in_payload_word = '0;
  logic [31:0] in_packet_count = '0;
  logic [8:0]  in_final_length = '0;
  logic        busy;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [63:0] out_payload_out;
  logic [8:0]  out_byte_length;
  logic [31:0] out_number_out;
  logic        out_run_end;

  rwca_scoreboard sb = new();

  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;
  // when set the sender stops idling between beats
  logic        no_idle      = 1'b0;

  reorder_window_cumulative_ack u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_sequence_req (in_sequence_req),
    .in_payload_word (in_payload_word),
    .in_packet_count (in_packet_count),
    .in_final_length (in_final_length),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_payload_out (out_payload_out),
    .out_byte_length (out_byte_length),
    .out_number_out  (out_number_out),
    .out_run_end     (out_run_end)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // results are taken at the edge that ends their strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_kind, out_payload_out, out_byte_length, out_number_out,
                      out_run_end);
  end

  // watchdog: count cycles with neither an accepted beat nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("reorder_window_cumulative_ack_tb: errors");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one beat and hold it until the block takes it; start is only
  // lowered when a gap follows, so back-to-back beats keep it high
  task automatic send_beat(op_t op, logic [31:0] seq, logic [63:0] pay,
                           logic [31:0] cnt, logic [8:0] flen);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation    <= op;
    in_sequence_req <= seq;
    in_payload_word <= pay;
    in_packet_count <= cnt;
    in_final_length <= flen;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(op, seq, pay, cnt, flen);
    beats_sent++;
  endtask

  // data beat with random payload; count and length fields are don't-care
  task automatic send_data(logic [31:0] seq);
    send_beat(OP_DATA, seq, rand64(), $urandom, 9'($urandom));
  endtask

  // sender holds off until every pending result has come out
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  // beats off the well-formed path: junk, stale, out of window, re-open
  task automatic send_noise();
    logic [31:0] seq;
    case ($urandom_range(0, 4))
      0: send_beat(OP_BAD, $urandom, rand64(), $urandom, 9'($urandom));
      1: begin
        // at or below the in-order high mark, may wrap far ahead
        seq = sb.in_order_high - $urandom_range(0, 40);
        send_data(seq);
      end
      2: begin
        // just past the window edge
        seq = sb.in_order_high + 32'd1 + WINDOW + $urandom_range(0, 3);
        send_data(seq);
      end
      3: send_data($urandom);
      default: send_beat(OP_OPEN, $urandom, rand64(), $urandom_range(0, 8),
                         9'($urandom));
    endcase
  endtask

  // one connection's worth: open, then batches of at most a window sent shuffled
  task automatic run_episode();
    logic [31:0] order [WINDOW];
    logic [31:0] base;
    logic [31:0] tmp;
    logic [31:0] cnt;
    int unsigned pkts;
    int unsigned left;
    int unsigned k;
    int unsigned j;
    int unsigned pick;
    pkts = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 24);
    cnt  = ($urandom_range(0, 3) == 0) ? $urandom : pkts;
    send_beat(OP_OPEN, $urandom, rand64(), cnt, 9'($urandom_range(0, 511)));
    left = pkts;
    while (left > 0) begin
      k = (left > WINDOW) ? WINDOW : left;
      if ($urandom_range(0, 2) != 0) k = $urandom_range(1, k);
      base = sb.in_order_high + 32'd1;
      for (j = 0; j < k; j++) order[j] = base + j;
      for (j = k - 1; j > 0; j--) begin
        pick     = $urandom_range(0, j);
        tmp      = order[j];
        order[j] = order[pick];
        order[pick] = tmp;
      end
      // with the head packet last a full window drains in one run
      if (k == WINDOW && $urandom_range(0, 1) == 1) begin
        for (j = 0; j < k; j++) begin
          if (order[j] == base) begin
            order[j]   = order[k-1];
            order[k-1] = base;
          end
        end
      end
      for (j = 0; j < k; j++) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        send_data(order[j]);
        if ($urandom_range(0, 11) == 0) send_data(order[j]);
      end
      left = left - k;
    end
  endtask

  initial begin
    int unsigned first_random;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_beat(OP_BAD, '0, '0, '0, '0);
    send_data(32'd0);                              // offset wraps, out of window
    send_beat(OP_DATA, 32'hFFFF_FFFF, rand64(), '1, '1);
    // delivery before any open: count is zero, tail length still zero
    send_beat(OP_DATA, 32'd1, '1, '0, '0);
    send_beat(OP_OPEN, '1, '1, 32'd3, 9'd0);        // zero length means full
    send_beat(OP_DATA, 32'd3, 64'h0123_4567_89AB_CDEF, '0, '0);
    send_beat(OP_DATA, 32'd3, 64'hFEDC_BA98_7654_3210, '0, '0);  // overwrite
    send_data(32'd33);                             // last slot of the window
    send_data(32'd34);                             // one past the window
    send_data(32'd2);                              // releases 2 and 3
    send_data(32'd1);                              // stale
    send_beat(OP_OPEN, '0, '0, 32'hFFFF_FFFF, 9'd511);  // over 500 saturates
    send_beat(OP_OPEN, '0, '0, 32'd2, 9'd1);
    send_data(32'd4);
    send_data(32'd5);                              // count reaches zero: tail length
    send_data(32'd6);                              // count stays at zero
    send_beat(OP_OPEN, '0, '0, 32'd1, 9'd500);
    send_beat(OP_DATA, 32'd7, '0, '0, '0);
    send_beat(OP_OPEN, '0, '0, 32'd0, 9'd256);
    send_data(32'd8);
    send_beat(OP_BAD, '1, '1, '1, '1);
    drain_results();

    // random part: mostly well-formed connections with noise mixed in
    first_random = beats_sent;
    while (beats_sent - first_random < RANDOM_BEATS) begin
      if ($urandom_range(0, 4) == 0) drain_results();
      no_idle = ($urandom_range(0, 3) == 0);
      run_episode();
    end
    no_idle = 1'b0;

    // after close acks are gone for good, deliveries and replies remain
    send_beat(OP_CLOSE, $urandom, rand64(), $urandom, 9'($urandom));
    repeat (CLOSED_BEATS) begin
      case ($urandom_range(0, 5))
        0, 1: send_data(sb.in_order_high + 32'd1);
        2: send_data(sb.in_order_high + 32'd1 + $urandom_range(1, WINDOW - 1));
        3: send_noise();
        4: send_beat(OP_OPEN, $urandom, rand64(), $urandom_range(0, 4), 9'($urandom));
        default: send_beat(OP_CLOSE, $urandom, rand64(), $urandom, 9'($urandom));
      endcase
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    // let a beat that causes no result finish, and catch any stray strobe
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("reorder_window_cumulative_ack_tb: clean");
    end else begin
      $display("reorder_window_cumulative_ack_tb: errors");
    end
    $finish;
  end

endmodule

>>> reorder_window_cumulative_ack.f
sv/rwca_pkg.sv
sv/rwca_alu.sv
sv/rwca_slots.sv
sv/reorder_window_cumulative_ack.sv
sim/rwca_scoreboard_pkg.sv
sim/reorder_window_cumulative_ack_tb.sv
